/* rtl/core/etwc_pkg.sv */
// etwc_pkg: shared constants, codes and word types for the waveform capture engine
// no dependencies; used by edge_trigger_waveform_capture
package etwc_pkg;

    localparam int CAPTURE_LENGTH = 4000;
    localparam int STORE_DEPTH    = 4096;
    localparam int SAMPLE_BITS    = 10;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CNT_MAX = (CAPTURE_LENGTH > STORE_DEPTH) ? CAPTURE_LENGTH : STORE_DEPTH;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam int FUNC_W     = 2;
    localparam int IN_SMP_W   = 10;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // item kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ARM    = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_DRAIN  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FALLING_EDGE  = 1'b0,
        CFG_TRIGGER_LEVEL = 1'b1
    } cfg_idx_t;

    // capture modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_BELOW = 5'b00010,
        MODE_ABOVE = 5'b00100,
        MODE_SAVE  = 5'b01000,
        MODE_DRAIN = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [IN_SMP_W-1:0] sample;
    } req_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } rsp_word_t;

endpackage

/* rtl/core/etwc_ram.sv */
// etwc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module etwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/edge_trigger_waveform_capture.sv */
// edge_trigger_waveform_capture: top level of the oscilloscope capture engine
// depends on etwc_pkg and etwc_ram
//
// An arm word starts a capture. With a rising trigger (falling_edge = 0) the engine
// waits for a sample strictly below trigger_level, then for one strictly above it;
// a falling trigger is the mirror image. The crossing sample and the ones after it
// go into the sample store until CAPTURE_LENGTH are held, then each drain word
// returns one stored sample as its top eight bits, the final one marked by last.
// Samples outside a capture and drains outside draining are dropped without a
// result. Arm, sample and ignored words need no store read, so a sample stream
// runs at one word per clock while the request side does not stall. A drain
// goes through the store read, whose data is registered inside the ram, and then
// the load of the output register; the request side stalls during that read and
// while a result sits stalled in the output register. The store is not cleared
// after reset; an entry is read only after the capture has written it.
module edge_trigger_waveform_capture (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  etwc_pkg::req_word_t                 req,
    // result channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output etwc_pkg::rsp_word_t                 rsp,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etwc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [etwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic                              falling_edge_reg;
    logic [etwc_pkg::CFG_DATA_W-1:0]   trigger_level_reg;

    // control state
    etwc_pkg::mode_t                   mode_reg, mode_next;
    logic [etwc_pkg::CNT_W-1:0]        wcount_reg, wcount_next;
    logic [etwc_pkg::CNT_W-1:0]        rptr_reg, rptr_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic                              rd_last_reg, rd_last_next;
    logic                              rd_zero_reg, rd_zero_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    etwc_pkg::rsp_word_t               rsp_reg;

    // store port signals
    logic                              ram_we;
    logic [etwc_pkg::SAMPLE_BITS-1:0]  ram_wdata;
    logic [etwc_pkg::SAMPLE_BITS-1:0]  ram_rdata;

    logic                              req_take;
    logic                              rsp_take;
    logic [etwc_pkg::CNT_W-1:0]        wcount_inc;
    logic [etwc_pkg::CNT_W-1:0]        rptr_inc;
    logic [etwc_pkg::CFG_DATA_W-1:0]   smp_ext;
    logic                              smp_lo;
    logic                              smp_hi;
    logic                              arm_hit;
    logic                              cross_hit;

    assign cfg_ready = 1'b1;

    // stall while a store read is in flight or a result is held up downstream
    assign req_stall = rd_pend_reg || (rsp_valid_reg && rsp_stall);
    assign req_take  = req_valid && !req_stall;
    assign rsp_take  = rsp_valid_reg && !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign wcount_inc = wcount_reg + 1'b1;
    assign rptr_inc   = rptr_reg + 1'b1;

    // trigger compares against the level
    assign smp_ext   = etwc_pkg::CFG_DATA_W'(req.sample);
    assign smp_lo    = smp_ext < trigger_level_reg;
    assign smp_hi    = smp_ext > trigger_level_reg;
    assign arm_hit   = falling_edge_reg ? smp_hi : smp_lo;
    assign cross_hit = falling_edge_reg ? smp_lo : smp_hi;

    assign ram_wdata = etwc_pkg::SAMPLE_BITS'(req.sample);

    always_comb
    begin
        mode_next      = mode_reg;
        wcount_next    = wcount_reg;
        rptr_next      = rptr_reg;
        rd_pend_next   = 1'b0;
        rd_last_next   = rd_last_reg;
        rd_zero_next   = rd_zero_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;

        if (rsp_take)
        begin
            rsp_valid_next = 1'b0;
        end
        // a pending store read turns into a valid result in the output register
        if (rd_pend_reg)
        begin
            rsp_valid_next = 1'b1;
        end

        if (req_take)
        begin
            case (etwc_pkg::func_t'(req.func))
                etwc_pkg::FUNC_ARM:
                begin
                    wcount_next = '0;
                    rptr_next   = '0;
                    mode_next   = etwc_pkg::MODE_BELOW;
                end
                etwc_pkg::FUNC_SAMPLE:
                begin
                    unique case (mode_reg)
                        etwc_pkg::MODE_BELOW:
                        begin
                            if (arm_hit)
                            begin
                                mode_next = etwc_pkg::MODE_ABOVE;
                            end
                        end
                        etwc_pkg::MODE_ABOVE, etwc_pkg::MODE_SAVE:
                        begin
                            if (mode_reg == etwc_pkg::MODE_SAVE || cross_hit)
                            begin
                                mode_next   = etwc_pkg::MODE_SAVE;
                                ram_we      = wcount_reg < etwc_pkg::CNT_W'(etwc_pkg::STORE_DEPTH);
                                wcount_next = wcount_inc;
                                // capture full: hand over to draining
                                if (wcount_inc >= etwc_pkg::CNT_W'(etwc_pkg::CAPTURE_LENGTH))
                                begin
                                    mode_next = etwc_pkg::MODE_DRAIN;
                                    rptr_next = '0;
                                end
                            end
                        end
                        etwc_pkg::MODE_IDLE, etwc_pkg::MODE_DRAIN:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
                etwc_pkg::FUNC_DRAIN:
                begin
                    if (mode_reg == etwc_pkg::MODE_DRAIN)
                    begin
                        rd_pend_next = 1'b1;
                        rd_last_next = rptr_inc >= etwc_pkg::CNT_W'(etwc_pkg::CAPTURE_LENGTH);
                        rd_zero_next = rptr_reg >= etwc_pkg::CNT_W'(etwc_pkg::STORE_DEPTH);
                        rptr_next    = rptr_inc;
                        if (rd_last_next)
                        begin
                            mode_next = etwc_pkg::MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            falling_edge_reg  <= 1'b0;
            trigger_level_reg <= '0;
            mode_reg          <= etwc_pkg::MODE_IDLE;
            wcount_reg        <= '0;
            rptr_reg          <= '0;
            rd_pend_reg       <= 1'b0;
            rd_last_reg       <= 1'b0;
            rd_zero_reg       <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (etwc_pkg::cfg_idx_t'(cfg_index))
                    etwc_pkg::CFG_FALLING_EDGE:  falling_edge_reg  <= cfg_data[0];
                    etwc_pkg::CFG_TRIGGER_LEVEL: trigger_level_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            mode_reg      <= mode_next;
            wcount_reg    <= wcount_next;
            rptr_reg      <= rptr_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            rd_zero_reg   <= rd_zero_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // output payload register, loaded from the store read
    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            rsp_reg.data_byte <= rd_zero_reg ? '0
                                 : ram_rdata[etwc_pkg::SAMPLE_BITS-1 -: etwc_pkg::BYTE_W];
            rsp_reg.last      <= rd_last_reg;
        end
    end

    // sample store: writes at the crossing and while saving, reads while draining, so never both on one entry
    etwc_ram #(
        .WIDTH (etwc_pkg::SAMPLE_BITS),
        .DEPTH (etwc_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wcount_reg[etwc_pkg::ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rptr_reg[etwc_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // a pending read always turns into a result on the next cycle
    a_read_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> rsp_valid_reg)
        else $error("store read did not produce a result");

    // the final byte leaves the engine idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.last) |-> (mode_reg == etwc_pkg::MODE_IDLE))
        else $error("final byte shown while capture still active");

    // store writes only happen around the trigger crossing or while saving
    a_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (mode_reg == etwc_pkg::MODE_ABOVE || mode_reg == etwc_pkg::MODE_SAVE))
        else $error("store written outside a capture");

    // draining only with a full capture held
    a_drain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == etwc_pkg::MODE_DRAIN)
            |-> (wcount_reg >= etwc_pkg::CNT_W'(etwc_pkg::CAPTURE_LENGTH)))
        else $error("draining before the capture is complete");

endmodule

/* tb/edge_trigger_waveform_capture_test.sv */
// edge_trigger_waveform_capture_test: self-checking bench for the waveform capture engine
// holds a cycle-free shadow of the engine in a small class; depends on etwc_pkg and the rtl
// directed trigger corner cases, then full and broken captures under random handshake idling
module edge_trigger_waveform_capture_test;

    import etwc_pkg::*;

    // settle time after the last expected byte, with margin beyond a drain's store read and output load
    localparam int SETTLE      = 8;
    // receiver hold-off long enough to back the engine up into its request side
    localparam int HOLD_CYCLES = 300;
    localparam int SMP_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int FULL_SAVE   = CAPTURE_LENGTH - 1;
    localparam int NOISE_WORDS = 1550;

    // which part of the trigger window a generated sample falls in
    typedef enum {
        PICK_QUIET,     // does not arm the trigger
        PICK_ARM,       // arms it (below the level on a rising edge)
        PICK_HOLD,      // armed, but does not cross
        PICK_CROSS      // crosses the level, first stored sample
    } pick_t;

    // ------------------------------------------------------------------
    // shadow of the capture engine: mode, store and pointers at word level
    // ------------------------------------------------------------------
    class waveform_shadow;
        logic                   falling;
        logic [SAMPLE_BITS-1:0] level;
        mode_t                  mode;
        logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];
        int unsigned            wr_count;
        int unsigned            rd_ptr;
        rsp_word_t              bytes_due [$];
        int                     mismatches;
        int                     bytes_checked;
        int                     captures_drained;

        function new();
            falling  = 1'b0;
            level    = '0;
            mode     = MODE_IDLE;
            wr_count = 0;
            rd_ptr   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_FALLING_EDGE:  falling = d[0];
                CFG_TRIGGER_LEVEL: level   = d[SAMPLE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void keep_sample(logic [SAMPLE_BITS-1:0] s);
            if (wr_count < STORE_DEPTH)
                store[wr_count] = s;
            wr_count++;
            if (wr_count >= CAPTURE_LENGTH)
            begin
                mode   = MODE_DRAIN;
                rd_ptr = 0;
            end
        endfunction

        function void note_word(req_word_t w);
            rsp_word_t              b;
            logic [SAMPLE_BITS-1:0] v;
            case (func_t'(w.func))
                FUNC_ARM:
                begin
                    wr_count = 0;
                    rd_ptr   = 0;
                    mode     = MODE_BELOW;
                end
                FUNC_SAMPLE:
                begin
                    case (mode)
                        MODE_BELOW:
                            if (falling ? (w.sample > level) : (w.sample < level))
                                mode = MODE_ABOVE;
                        MODE_ABOVE:
                            if (falling ? (w.sample < level) : (w.sample > level))
                            begin
                                mode = MODE_SAVE;
                                keep_sample(w.sample);
                            end
                        MODE_SAVE:
                            keep_sample(w.sample);
                        default: ;
                    endcase
                end
                FUNC_DRAIN:
                begin
                    if (mode == MODE_DRAIN)
                    begin
                        v           = (rd_ptr < STORE_DEPTH) ? store[rd_ptr] : '0;
                        b.data_byte = v[SAMPLE_BITS-1 -: BYTE_W];
                        b.last      = (rd_ptr + 1 >= CAPTURE_LENGTH);
                        bytes_due.push_back(b);
                        rd_ptr++;
                        if (b.last)
                            mode = MODE_IDLE;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_byte(rsp_word_t got);
            rsp_word_t want;
            if (bytes_due.size() == 0)
            begin
                $display("%0t: byte with nothing expected, expected none, actual %h last %b",
                         $time, got.data_byte, got.last);
                mismatches++;
                return;
            end
            want = bytes_due.pop_front();
            bytes_checked++;
            if (got.data_byte !== want.data_byte)
            begin
                $display("%0t: data_byte expected %h actual %h",
                         $time, want.data_byte, got.data_byte);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                mismatches++;
            end
            if (want.last)
                captures_drained++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, dut and bench state
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_word_t             req;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsp_word_t             rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    waveform_shadow        shadow = new;

    // trigger setting as last written, used to shape well-formed captures
    logic                   trig_falling = 1'b0;
    logic [SAMPLE_BITS-1:0] cur_level    = '0;

    int burst_left    = 0;  // words left in the current sender burst
    int words_sent    = 0;
    int hold_requests = 0;  // raised by the stimulus, served by the receiver
    int hold_served   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    edge_trigger_waveform_capture u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // monitor: everything is sampled at the edge, before any update lands
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a byte leaving now always stems from an earlier word, so check first
            if (rsp_valid && !rsp_stall)
                shadow.check_byte(rsp);
            if (req_valid && !req_stall)
                shadow.note_word(req);
            if (cfg_valid && cfg_ready)
                shadow.write_reg(cfg_idx_t'(cfg_index), cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern changes in windows; a hold-off request wins
    // ------------------------------------------------------------------
    initial
    begin
        int style;
        int window;
        int hold_left;
        style     = 0;
        window    = 0;
        hold_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (window == 0)
            begin
                style  = $urandom_range(3, 0);
                window = $urandom_range(256, 16);
            end
            window--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (style)
                    0:       rsp_stall <= 1'b0;                       // free running
                    1:       rsp_stall <= ($urandom_range(3, 0) == 0); // light
                    2:       rsp_stall <= ($urandom_range(3, 0) != 0); // heavy
                    default: rsp_stall <= ((window & 4) != 0);         // regular beat
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------

    // offers one word in bursts of random length separated by random gaps
    task automatic offer(input func_t f, input logic [SAMPLE_BITS-1:0] s);
        req_word_t w;
        int        gap;
        w.func   = f;
        w.sample = s;
        if (burst_left == 0)
        begin
            gap = $urandom_range(6, 0);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long unbroken stretch
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(400, 100)
                                                     : $urandom_range(24, 1);
        end
        req       <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        burst_left--;
        words_sent++;
    endtask

    // stray words the engine must drop in the current phase
    task automatic maybe_stray(input bit draining);
        if ($urandom_range(23, 0) == 0)
        begin
            if ($urandom_range(1, 0))
                offer(FUNC_NONE, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
            else if (draining)
                offer(FUNC_SAMPLE, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
            else
                offer(FUNC_DRAIN, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        end
    endtask

    // idle the request side until every byte owed has come, then let it settle
    task automatic wait_quiet();
        req_valid <= 1'b0;
        burst_left = 0;
        // one edge first so that the monitor has noted the last accepted word
        @(posedge clk);
        while (shadow.bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // writes both trigger registers back to back; only called with no byte outstanding
    task automatic configure(input logic fall, input logic [SAMPLE_BITS-1:0] lvl);
        cfg_index <= CFG_FALLING_EDGE;
        cfg_data  <= CFG_DATA_W'(fall);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_TRIGGER_LEVEL;
        cfg_data  <= CFG_DATA_W'(lvl);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        trig_falling = fall;
        cur_level    = lvl;
    endtask

    // sample in a chosen part of the trigger window; level must lie strictly inside
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input pick_t k);
        int unsigned l;
        bit          upper;
        l = cur_level;
        // on a rising edge quiet samples sit at or above the level and crossing samples above it
        upper = ((k == PICK_QUIET) || (k == PICK_CROSS)) ^ trig_falling;
        case (k)
            PICK_QUIET, PICK_HOLD:
                return SAMPLE_BITS'(upper ? $urandom_range(SMP_MAX, l)
                                          : $urandom_range(l, 0));
            default:
                return SAMPLE_BITS'(upper ? $urandom_range(SMP_MAX, l + 1)
                                          : $urandom_range(l - 1, 0));
        endcase
    endfunction

    // one capture: arm, trigger search, save, drain; either stage can be cut short
    // so that the next arm lands mid-save or mid-drain
    task automatic run_capture(input int save_cut, input int drain_cut,
                               input int hold_at, input int pause_at);
        int n;
        offer(FUNC_ARM, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        n = $urandom_range(6, 0);
        repeat (n)
        begin
            maybe_stray(1'b0);
            offer(FUNC_SAMPLE, pick_sample(PICK_QUIET));
        end
        offer(FUNC_SAMPLE, pick_sample(PICK_ARM));
        n = $urandom_range(6, 0);
        repeat (n)
        begin
            maybe_stray(1'b0);
            offer(FUNC_SAMPLE, pick_sample(PICK_HOLD));
        end
        offer(FUNC_SAMPLE, pick_sample(PICK_CROSS));
        for (int i = 0; i < save_cut; i++)
        begin
            maybe_stray(1'b0);
            offer(FUNC_SAMPLE, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        end
        if (save_cut < FULL_SAVE)
            return;
        for (int i = 0; i < drain_cut; i++)
        begin
            if (i == hold_at)
                hold_requests++;
            if (i == pause_at)
                wait_quiet();
            maybe_stray(1'b1);
            offer(FUNC_DRAIN, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        end
        // after the final byte the engine is idle again: both of these are dropped
        if (drain_cut == CAPTURE_LENGTH)
        begin
            offer(FUNC_DRAIN, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
            offer(FUNC_SAMPLE, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int guard;
        int f;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rising edge at mid scale
        configure(1'b0, 10'd512);
        offer(FUNC_SAMPLE, 10'd0);      // idle, dropped
        offer(FUNC_DRAIN,  10'd0);      // nothing to drain
        offer(FUNC_NONE,   SAMPLE_BITS'(SMP_MAX));    // unused code
        offer(FUNC_ARM,    SAMPLE_BITS'(SMP_MAX));
        offer(FUNC_DRAIN,  10'd0);      // still searching, dropped
        offer(FUNC_SAMPLE, SAMPLE_BITS'(SMP_MAX));    // not below, keeps waiting
        offer(FUNC_SAMPLE, 10'd0);      // below, armed
        offer(FUNC_SAMPLE, 10'd512);    // equal to the level, no crossing
        offer(FUNC_ARM,    10'd0);      // restart while armed
        offer(FUNC_SAMPLE, 10'd100);
        offer(FUNC_SAMPLE, SAMPLE_BITS'(SMP_MAX));    // crossing, first stored sample
        offer(FUNC_SAMPLE, 10'd0);
        offer(FUNC_DRAIN,  SAMPLE_BITS'(SMP_MAX));    // still saving, dropped
        offer(FUNC_NONE,   10'd0);
        offer(FUNC_ARM,    10'd0);      // restart while saving
        offer(FUNC_SAMPLE, 10'd511);    // armed again

        // directed: trigger change while armed, level at the bottom, falling edge
        wait_quiet();
        configure(1'b1, 10'd0);
        offer(FUNC_SAMPLE, SAMPLE_BITS'(SMP_MAX));
        offer(FUNC_SAMPLE, 10'd0);      // nothing lies below zero

        // directed: level at the top, rising edge, nothing can cross
        wait_quiet();
        configure(1'b0, SAMPLE_BITS'(SMP_MAX));
        offer(FUNC_SAMPLE, 10'd1022);
        offer(FUNC_SAMPLE, SAMPLE_BITS'(SMP_MAX));
        offer(FUNC_ARM,    10'd0);
        offer(FUNC_SAMPLE, 10'd0);
        offer(FUNC_SAMPLE, SAMPLE_BITS'(SMP_MAX));

        // full capture on a rising edge
        wait_quiet();
        configure(1'b0, SAMPLE_BITS'($urandom_range(SMP_MAX - 1, 1)));
        run_capture(FULL_SAVE, CAPTURE_LENGTH, -1, -1);

        // falling edge, cut off while saving
        wait_quiet();
        configure(1'b1, SAMPLE_BITS'($urandom_range(SMP_MAX - 1, 1)));
        run_capture($urandom_range(1500, 10), 0, -1, -1);

        // full falling capture: long receiver hold-off, then a pause mid-drain
        wait_quiet();
        configure(1'b1, SAMPLE_BITS'($urandom_range(SMP_MAX - 1, 1)));
        run_capture(FULL_SAVE, CAPTURE_LENGTH, 100, 2000);

        // cut off part way through the drain; the next arm lands while draining
        wait_quiet();
        configure(1'($urandom_range(1, 0)), SAMPLE_BITS'($urandom_range(SMP_MAX - 1, 1)));
        run_capture(FULL_SAVE, $urandom_range(600, 50), -1, -1);

        wait_quiet();
        configure(1'($urandom_range(1, 0)), SAMPLE_BITS'($urandom_range(SMP_MAX - 1, 1)));
        run_capture(FULL_SAVE, CAPTURE_LENGTH, -1, -1);

        // free-form noise: arms are rare so partial captures build up
        wait_quiet();
        configure(1'($urandom_range(1, 0)), SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        repeat (NOISE_WORDS)
        begin
            f = $urandom_range(15, 0);
            if (f == 0)
                offer(FUNC_ARM, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
            else if (f <= 2)
                offer(FUNC_DRAIN, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
            else if (f == 3)
                offer(FUNC_NONE, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
            else
                offer(FUNC_SAMPLE, SAMPLE_BITS'($urandom_range(SMP_MAX, 0)));
        end

        // drain out, bounded in case bytes have gone missing
        req_valid <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (shadow.bytes_due.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
        if (shadow.bytes_due.size() != 0)
            $display("%0t: %0d bytes never came, expected %h last %b, actual none",
                     $time, shadow.bytes_due.size(),
                     shadow.bytes_due[0].data_byte, shadow.bytes_due[0].last);

        $display("%0d words offered, %0d bytes checked, %0d captures drained to the end",
                 words_sent, shadow.bytes_checked, shadow.captures_drained);
        $display("both trigger edges, levels at both extremes, %0d receiver hold-offs",
                 hold_served);
        if (shadow.mismatches == 0 && shadow.bytes_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #10000000;
        $display("%0t: run timed out", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
